// File: sv/assert_macros.svh
// Assertion macros shared by the circular list ring RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CLR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CLR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/clr_pkg.sv
// Shared types and constants for the circular list ring.
// Used by clr_cell and circular_list_ring; depends on nothing.
package clr_pkg;

	localparam int WORD_W  = 32;
	localparam int COUNT_W = 5;

	typedef logic signed [WORD_W-1:0] word_t;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_ROTATE = 2'd2,
		REQ_QUERY  = 2'd3
	} req_t;

	// Moves applied to the whole row of cells at once.
	typedef struct packed {
		logic shift_in;   // every cell takes its front-side neighbour
		logic shift_out;  // every cell takes its back-side neighbour
		logic rotate;     // live cells move forward, the tail takes the front
	} cell_ctl_t;

endpackage

// File: sv/clr_cell.sv
// One storage cell of the circular list ring: holds the entry at a fixed
// list position and compares it against the search key. Uses clr_pkg.
module clr_cell #(
	parameter int IDX   = 0,
	parameter int CNT_W = 5
) (
	input  logic              clk,
	input  clr_pkg::cell_ctl_t ctl,
	input  logic [CNT_W-1:0]  count,
	input  clr_pkg::word_t    prev_data,
	input  clr_pkg::word_t    next_data,
	input  clr_pkg::word_t    front_data,
	input  clr_pkg::word_t    key,
	output clr_pkg::word_t    data,
	output clr_pkg::word_t    data_nxt,
	output logic              match
);
	import clr_pkg::*;

	word_t data_q;
	logic  live;
	logic  tail;

	assign live = CNT_W'(IDX) < count;
	assign tail = count == CNT_W'(IDX + 1);

	always_comb begin
		data_nxt = data_q;
		priority if (ctl.shift_in) begin
			data_nxt = prev_data;
		end else if (ctl.shift_out) begin
			data_nxt = next_data;
		end else if (ctl.rotate) begin
			if (tail) begin
				data_nxt = front_data;
			end else if (live) begin
				data_nxt = next_data;
			end
		end else begin
			data_nxt = data_q;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_nxt;
	end

	assign data  = data_q;
	assign match = live && (data_q == key);

endmodule

// File: sv/circular_list_ring.sv
// circular_list_ring: a bounded list of signed 32-bit words, held as a row
// of RING_CAPACITY cells in which cell 0 is always the front of the list.
// Each request transfer on the slave side carries a request kind in s_tuser
// (insert at front, remove front, rotate front to back, membership query)
// and a value in s_tdata; it produces exactly one result transfer on the
// master side with the front item, its valid flag, the entry count and the
// found and rejected flags. An insert moves every cell one place back, a
// remove moves every cell one place forward, and a rotate moves the live
// cells forward while the tail cell takes the old front; a query compares
// every live cell against the value at once and ORs the hits. The block
// takes one request per cycle for as long as the result register is empty
// or being drained in the same cycle; the result is registered and shows
// in the cycle after the request is accepted. An insert into a full list
// is dropped and flagged. The entry count on the port is the low five
// bits of the internal count. The cell storage has no reset; only cells
// holding live entries are read.
`include "assert_macros.svh"

module circular_list_ring #(
	parameter int RING_CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // [31:0] front_item, [32] front_valid,
	                                // [37:33] entry_count, [38] found, [39] rejected
);
	import clr_pkg::*;

	localparam int CNT_W = $clog2(RING_CAPACITY + 1);

	// Request decode.
	logic      accept;
	req_t      req;
	word_t     value;
	cell_ctl_t ctl;
	logic      full;
	logic      empty;
	logic      several;
	logic      ins_ok;
	logic      rem_ok;
	logic      rot_ok;
	logic      rejected;
	logic      found;

	// Count of stored entries.
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;

	// Row of cells.
	word_t                    cell_data [RING_CAPACITY];
	word_t                    cell_nxt  [RING_CAPACITY];
	logic [RING_CAPACITY-1:0] cell_match;

	// Result register.
	logic             m_tvalid_q;
	word_t            front_item_q;
	logic             front_valid_q;
	logic [CNT_W-1:0] count_out_q;
	logic             found_q;
	logic             rejected_q;

	// The result register parts the two sides: a new request is taken while
	// it is empty or while the previous result is being taken in the same cycle.
	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign req      = req_t'(s_tuser);
	assign value    = word_t'(s_tdata);

	assign full    = count_q >= CNT_W'(RING_CAPACITY);
	assign empty   = count_q == '0;
	assign several = count_q > CNT_W'(1);

	assign ins_ok   = accept && (req == REQ_INSERT) && !full;
	assign rem_ok   = accept && (req == REQ_REMOVE) && !empty;
	assign rot_ok   = accept && (req == REQ_ROTATE) && several;
	assign rejected = (req == REQ_INSERT) && full;
	assign found    = (req == REQ_QUERY) && (|cell_match);

	assign ctl.shift_in  = ins_ok;
	assign ctl.shift_out = rem_ok;
	assign ctl.rotate    = rot_ok;

	always_comb begin
		count_nxt = count_q;
		if (ins_ok) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (rem_ok) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	// Cell 0 takes the new value on an insert; the last cell keeps its own
	// data when the row moves forward, since it then lies beyond the list.
	for (genvar i = 0; i < RING_CAPACITY; i++) begin : g_cell
		word_t prev_d;
		word_t next_d;

		if (i == 0) begin : g_first
			assign prev_d = value;
		end else begin : g_mid_prev
			assign prev_d = cell_data[i-1];
		end

		if (i == RING_CAPACITY - 1) begin : g_last
			assign next_d = cell_data[i];
		end else begin : g_mid_next
			assign next_d = cell_data[i+1];
		end

		clr_cell #(
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.count      (count_q),
			.prev_data  (prev_d),
			.next_data  (next_d),
			.front_data (cell_data[0]),
			.key        (value),
			.data       (cell_data[i]),
			.data_nxt   (cell_nxt[i]),
			.match      (cell_match[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (accept) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Result payload: the front after the request is cell 0's next value.
	always_ff @(posedge clk) begin
		if (accept) begin
			front_valid_q <= count_nxt != '0;
			front_item_q  <= (count_nxt != '0) ? cell_nxt[0] : '0;
			count_out_q   <= count_nxt;
			found_q       <= found;
			rejected_q    <= rejected;
		end
	end

	assign m_tvalid = m_tvalid_q;

	always_comb begin
		m_tdata        = '0;
		m_tdata[31:0]  = front_item_q;
		m_tdata[32]    = front_valid_q;
		m_tdata[37:33] = COUNT_W'(count_out_q);
		m_tdata[38]    = found_q;
		m_tdata[39]    = rejected_q;
	end

	// The stored count never exceeds the number of cells.
	`CLR_ASSERT_NOW(a_count_bounded, 1'b1, count_q <= CNT_W'(RING_CAPACITY),
		"entry count exceeds ring capacity")

	// A pending result flags a valid front exactly when the list is not empty after the request.
	`CLR_ASSERT_NOW(a_front_valid, m_tvalid_q, front_valid_q == (count_out_q != '0),
		"front valid flag disagrees with reported count")

	// A rejected insert leaves the count untouched.
	`CLR_ASSERT_NEXT(a_reject_holds, accept && rejected, count_q == $past(count_q),
		"rejected insert changed the entry count")

	// The row of cells only moves in one way at a time.
	`CLR_ASSERT_NOW(a_one_move, 1'b1, $onehot0({ctl.shift_in, ctl.shift_out, ctl.rotate}),
		"more than one cell move requested in a cycle")

endmodule
